// File: src/c2d_pkg.sv
// c2d_pkg: shared constants, codes and types of the fixed-point 2-D convolution block
// used by c2d_mac and fixed_point_2d_convolution; no dependencies
`default_nettype none

package c2d_pkg;

	localparam int MAX_WINDOW_COLS = 5;
	localparam int MAX_WINDOW_ROWS = 5;
	localparam int MAX_LINE_PIXELS = 1024;
	localparam int MAX_LINES       = 1024;
	localparam int FRACTION_SCALE  = 8192;

	localparam int MAX_WINDOW = (MAX_WINDOW_COLS > MAX_WINDOW_ROWS) ?
		MAX_WINDOW_COLS : MAX_WINDOW_ROWS;
	localparam int FRAC_BITS  = $clog2(FRACTION_SCALE);
	localparam int NUM_COEFS  = MAX_WINDOW_COLS * MAX_WINDOW_ROWS;
	localparam int TAP_W      = $clog2(NUM_COEFS);
	localparam int HALF_W     = $clog2((MAX_WINDOW - 1) / 2 + 2);
	localparam int AGE_W      = $clog2(MAX_WINDOW_ROWS);
	localparam int LINE_AW    = $clog2(MAX_LINE_PIXELS);

	localparam int NUM_CH    = 3;
	localparam int PIX_W     = 8;
	localparam int WORD_W    = NUM_CH * PIX_W;
	localparam int ACC_W     = 32;
	localparam int COEF_W    = 32;
	localparam int POS_W     = 10;
	localparam int DIM_W     = 11;
	localparam int WSIZE_W   = 3;
	localparam int CIDX_W    = 5;
	localparam int CFG_IDX_W = 3;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_COEF  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_COLS  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_ROWS  = 3'd4;

	typedef logic [WORD_W-1:0] word_t;
	typedef word_t [MAX_WINDOW_ROWS-1:0][MAX_WINDOW_COLS-1:0] win_t;
	typedef logic [NUM_COEFS-1:0][COEF_W-1:0] coef_tab_t;

	typedef struct packed {
		logic [HALF_W-1:0] hp;
		logic [HALF_W-1:0] vp;
		logic              color;
	} mode_t;

	typedef struct packed {
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
	} pos_t;

endpackage

`default_nettype wire

// File: src/c2d_ram.sv
// c2d_ram: simple dual-port line buffer, one write and one registered read per cycle
// no dependencies
`default_nettype none

module c2d_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: src/c2d_mac.sv
// c2d_mac: tap products, registered adder tree, Q13 scaling and result register
// depends on c2d_pkg
`default_nettype none

module c2d_mac (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire c2d_pkg::win_t       win,
	input  wire c2d_pkg::coef_tab_t  coefs,
	input  wire c2d_pkg::mode_t      mode,
	input  wire c2d_pkg::pos_t       pos,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [c2d_pkg::POS_W-1:0] out_x,
	output logic [c2d_pkg::POS_W-1:0] out_y,
	output logic [c2d_pkg::PIX_W-1:0] out_ch0,
	output logic [c2d_pkg::PIX_W-1:0] out_ch1,
	output logic [c2d_pkg::PIX_W-1:0] out_ch2
);

	localparam int ROWS  = c2d_pkg::MAX_WINDOW_ROWS;
	localparam int COLS  = c2d_pkg::MAX_WINDOW_COLS;
	localparam int NCH   = c2d_pkg::NUM_CH;
	localparam int ACC_W = c2d_pkg::ACC_W;
	localparam int PIX_W = c2d_pkg::PIX_W;
	localparam int TAP_W = c2d_pkg::TAP_W;
	localparam int HW1   = c2d_pkg::HALF_W + 1;
	localparam logic [ACC_W-1:0] BIAS = ACC_W'(c2d_pkg::FRACTION_SCALE - 1);

	function automatic logic [TAP_W-1:0] coef_slot(input int a, input int b,
		input logic [c2d_pkg::HALF_W-1:0] hp, input logic [c2d_pkg::HALF_W-1:0] vp);
		logic [TAP_W-1:0] taps;
		logic [TAP_W-1:0] rr;
		logic [TAP_W-1:0] cc;
		taps = TAP_W'({hp, 1'b1});
		rr   = TAP_W'({vp, 1'b0}) - TAP_W'(a);
		cc   = TAP_W'({hp, 1'b0}) - TAP_W'(b);
		return TAP_W'(rr * taps + cc);
	endfunction

	logic en3, en4, en5, en_o;
	logic valid_s3, valid_s4, valid_s5, out_valid_q;

	logic [ACC_W-1:0] prod_d  [NCH][ROWS][COLS];
	logic [ACC_W-1:0] prod_s3 [NCH][ROWS][COLS];
	logic [ACC_W-1:0] rsum_d  [NCH][ROWS];
	logic [ACC_W-1:0] rsum_s4 [NCH][ROWS];
	logic [ACC_W-1:0] sum_d   [NCH];
	logic [ACC_W-1:0] sum_s5  [NCH];
	logic [PIX_W-1:0] scaled  [NCH];
	c2d_pkg::pos_t    pos_s3, pos_s4, pos_s5;
	c2d_pkg::pos_t    pos_q;
	logic [PIX_W-1:0] ch_q    [NCH];

	assign en_o     = !out_valid_q || out_ready;
	assign en5      = !valid_s5 || en_o;
	assign en4      = !valid_s4 || en5;
	assign en3      = !valid_s3 || en4;
	assign in_ready = en3;

	// per-tap coefficient pick and product, taps outside the window read as zero
	for (genvar a = 0; a < ROWS; a++) begin : g_row
		for (genvar b = 0; b < COLS; b++) begin : g_col
			logic                          in_win;
			logic [TAP_W-1:0]              slot;
			logic [c2d_pkg::COEF_W-1:0]    coef;
			assign in_win = (HW1'(a) <= {mode.vp, 1'b0}) && (HW1'(b) <= {mode.hp, 1'b0});
			assign slot   = coef_slot(a, b, mode.hp, mode.vp);
			assign coef   = in_win ? coefs[slot] : '0;
			for (genvar ch = 0; ch < NCH; ch++) begin : g_ch
				logic [PIX_W-1:0] pix;
				assign pix = (in_win && (ch == 0 || mode.color)) ?
					win[a][b][ch*PIX_W +: PIX_W] : '0;
				assign prod_d[ch][a][b] = ACC_W'(pix) * coef;
			end
		end
	end

	always_comb begin
		for (int ch = 0; ch < NCH; ch++) begin
			for (int a = 0; a < ROWS; a++) begin
				rsum_d[ch][a] = '0;
				for (int b = 0; b < COLS; b++) begin
					rsum_d[ch][a] = rsum_d[ch][a] + prod_s3[ch][a][b];
				end
			end
			sum_d[ch] = '0;
			for (int a = 0; a < ROWS; a++) begin
				sum_d[ch] = sum_d[ch] + rsum_s4[ch][a];
			end
		end
	end

	// divide by the scale with truncation toward zero, keep the low byte
	always_comb begin
		for (int ch = 0; ch < NCH; ch++) begin
			scaled[ch] = 8'(ACC_W'(sum_s5[ch] + (sum_s5[ch][ACC_W-1] ? BIAS : '0))
				>> c2d_pkg::FRAC_BITS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			valid_s5    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en3) valid_s3 <= in_valid;
			if (en4) valid_s4 <= valid_s3;
			if (en5) valid_s5 <= valid_s4;
			if (en_o) out_valid_q <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && in_valid) begin
			prod_s3 <= prod_d;
			pos_s3  <= pos;
		end
		if (en4 && valid_s3) begin
			rsum_s4 <= rsum_d;
			pos_s4  <= pos_s3;
		end
		if (en5 && valid_s4) begin
			sum_s5 <= sum_d;
			pos_s5 <= pos_s4;
		end
		if (en_o && valid_s5) begin
			ch_q  <= scaled;
			pos_q <= pos_s5;
		end
	end

	assign out_valid = out_valid_q;
	assign out_x     = pos_q.x;
	assign out_y     = pos_q.y;
	assign out_ch0   = ch_q[0];
	assign out_ch1   = ch_q[1];
	assign out_ch2   = ch_q[2];

endmodule

`default_nettype wire

// File: src/fixed_point_2d_convolution.sv
// fixed_point_2d_convolution: streaming Q13 2-D convolution, up to 5x5 taps, 1 or 3 channels
// depends on c2d_pkg, c2d_ram, c2d_mac
// path: pixel word -> line buffer read -> window -> products -> row sums -> sum -> output register
// throughput: one word per cycle unless out_ready stalls, set by one write and one read per line buffer bank
// reset: async active low, clears position, config to defaults, coefficients to zero
`default_nettype none

module fixed_point_2d_convolution (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              op,
	input  wire logic                              frame_start,
	input  wire logic [c2d_pkg::PIX_W-1:0]         pixel_ch0,
	input  wire logic [c2d_pkg::PIX_W-1:0]         pixel_ch1,
	input  wire logic [c2d_pkg::PIX_W-1:0]         pixel_ch2,
	input  wire logic [c2d_pkg::CIDX_W-1:0]        coef_index,
	input  wire logic signed [c2d_pkg::COEF_W-1:0] coef_value,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [c2d_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [c2d_pkg::DIM_W-1:0]         cfg_data,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [c2d_pkg::POS_W-1:0]              out_x,
	output logic [c2d_pkg::POS_W-1:0]              out_y,
	output logic [c2d_pkg::PIX_W-1:0]              out_ch0,
	output logic [c2d_pkg::PIX_W-1:0]              out_ch1,
	output logic [c2d_pkg::PIX_W-1:0]              out_ch2
);

	localparam int ROWS    = c2d_pkg::MAX_WINDOW_ROWS;
	localparam int COLS    = c2d_pkg::MAX_WINDOW_COLS;
	localparam int DIM_W   = c2d_pkg::DIM_W;
	localparam int POS_W   = c2d_pkg::POS_W;
	localparam int AGE_W   = c2d_pkg::AGE_W;
	localparam int WSIZE_W = c2d_pkg::WSIZE_W;
	localparam int HALF_W  = c2d_pkg::HALF_W;
	localparam int CIDX_W  = c2d_pkg::CIDX_W;

	function automatic logic [HALF_W-1:0] half_window(input logic [WSIZE_W-1:0] n,
		input int maxn);
		logic [WSIZE_W-1:0] m;
		m = n;
		if (m == '0) m = WSIZE_W'(1);
		if (int'(m) > maxn) m = WSIZE_W'(maxn);
		return HALF_W'((m - WSIZE_W'(1)) >> 1);
	endfunction

	function automatic logic [AGE_W-1:0] row_bank(input logic [AGE_W-1:0] slot, input int age);
		logic [AGE_W:0] t;
		t = {1'b0, slot} + (AGE_W+1)'(ROWS - age);
		if (t >= (AGE_W+1)'(ROWS)) t = t - (AGE_W+1)'(ROWS);
		return t[AGE_W-1:0];
	endfunction

	// configuration
	logic [DIM_W-1:0]   image_width_q, image_height_q;
	logic               color_mode_q;
	logic [WSIZE_W-1:0] window_cols_q, window_rows_q;

	// position
	logic [POS_W-1:0] col_q, row_q;
	logic [AGE_W-1:0] rmod_q;

	logic [DIM_W-1:0]  w_eff, h_eff;
	logic [HALF_W-1:0] hp, vp;
	logic [POS_W-1:0]  c0, r0, x, y, col_n, row_n;
	logic [AGE_W-1:0]  m0, m1, m, rmod_n;
	logic [DIM_W-1:0]  r1, nc, ny;
	logic              emit;
	logic              acc, acc_pix;

	// stage 1: line buffer read, stage 2: window
	logic                          valid_s1, valid_s2;
	logic                          op_s1, emit_s1;
	logic [CIDX_W-1:0]             cidx_s1;
	logic [c2d_pkg::COEF_W-1:0]    cval_s1;
	c2d_pkg::word_t                pix_s1;
	logic [AGE_W-1:0]              slot_s1;
	c2d_pkg::pos_t                 pos_s1, pos_s2;
	c2d_pkg::word_t                rd_word [ROWS];
	c2d_pkg::word_t                wr_word;
	c2d_pkg::win_t                 win_q;
	c2d_pkg::coef_tab_t            coef_q;
	c2d_pkg::mode_t                mode;
	logic                          en2, mac_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= DIM_W'(c2d_pkg::MAX_LINE_PIXELS);
			image_height_q <= DIM_W'(c2d_pkg::MAX_LINES);
			color_mode_q   <= 1'b0;
			window_cols_q  <= WSIZE_W'(3);
			window_rows_q  <= WSIZE_W'(3);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				c2d_pkg::CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				c2d_pkg::CFG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				c2d_pkg::CFG_COLOR_MODE:   color_mode_q   <= cfg_data[0];
				c2d_pkg::CFG_WINDOW_COLS:  window_cols_q  <= cfg_data[WSIZE_W-1:0];
				c2d_pkg::CFG_WINDOW_ROWS:  window_rows_q  <= cfg_data[WSIZE_W-1:0];
				default: ;
			endcase
		end
	end

	assign hp           = half_window(window_cols_q, c2d_pkg::MAX_WINDOW_COLS);
	assign vp           = half_window(window_rows_q, c2d_pkg::MAX_WINDOW_ROWS);
	assign mode.hp      = hp;
	assign mode.vp      = vp;
	assign mode.color   = color_mode_q;

	always_comb begin
		w_eff = image_width_q;
		if (image_width_q == '0) w_eff = DIM_W'(1);
		else if (image_width_q > DIM_W'(c2d_pkg::MAX_LINE_PIXELS))
			w_eff = DIM_W'(c2d_pkg::MAX_LINE_PIXELS);
		h_eff = image_height_q;
		if (image_height_q == '0) h_eff = DIM_W'(1);
		else if (image_height_q > DIM_W'(c2d_pkg::MAX_LINES))
			h_eff = DIM_W'(c2d_pkg::MAX_LINES);
	end

	// position of this word, then of the next one
	always_comb begin
		c0 = frame_start ? '0 : col_q;
		r0 = frame_start ? '0 : row_q;
		m0 = frame_start ? '0 : rmod_q;
		if ({1'b0, c0} >= w_eff) begin
			x  = '0;
			r1 = {1'b0, r0} + DIM_W'(1);
			m1 = (m0 == AGE_W'(ROWS - 1)) ? '0 : m0 + AGE_W'(1);
		end else begin
			x  = c0;
			r1 = {1'b0, r0};
			m1 = m0;
		end
		if (r1 >= h_eff) begin
			y = '0;
			m = '0;
		end else begin
			y = r1[POS_W-1:0];
			m = m1;
		end
		nc = {1'b0, x} + DIM_W'(1);
		ny = {1'b0, y} + DIM_W'(1);
		if (nc >= w_eff) begin
			col_n = '0;
			if (ny >= h_eff) begin
				row_n  = '0;
				rmod_n = '0;
			end else begin
				row_n  = ny[POS_W-1:0];
				rmod_n = (m == AGE_W'(ROWS - 1)) ? '0 : m + AGE_W'(1);
			end
		end else begin
			col_n  = nc[POS_W-1:0];
			row_n  = y;
			rmod_n = m;
		end
		emit = (x >= POS_W'({hp, 1'b0})) && (y >= POS_W'({vp, 1'b0}));
	end

	assign en2      = !valid_s2 || mac_ready;
	assign in_ready = !valid_s1 || en2;
	assign acc      = in_valid && in_ready;
	assign acc_pix  = acc && op == c2d_pkg::OP_PIXEL;
	assign wr_word  = {pixel_ch2, pixel_ch1, pixel_ch0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			rmod_q <= '0;
		end else if (acc_pix) begin
			col_q  <= col_n;
			row_q  <= row_n;
			rmod_q <= rmod_n;
		end
	end

	// one line buffer bank per window row, bank picked by row modulo the row count
	for (genvar i = 0; i < ROWS; i++) begin : g_bank
		c2d_ram #(
			.WIDTH(c2d_pkg::WORD_W),
			.DEPTH(c2d_pkg::MAX_LINE_PIXELS)
		) u_line (
			.clk  (clk),
			.we   (acc_pix && m == AGE_W'(i)),
			.waddr(x[c2d_pkg::LINE_AW-1:0]),
			.wdata(wr_word),
			.re   (acc_pix),
			.raddr(x[c2d_pkg::LINE_AW-1:0]),
			.rdata(rd_word[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			coef_q   <= '0;
		end else begin
			if (in_ready) valid_s1 <= acc;
			if (en2) valid_s2 <= valid_s1 && op_s1 == c2d_pkg::OP_PIXEL && emit_s1;
			if (en2 && valid_s1 && op_s1 == c2d_pkg::OP_COEF &&
				cidx_s1 < CIDX_W'(c2d_pkg::NUM_COEFS)) begin
				coef_q[cidx_s1[c2d_pkg::TAP_W-1:0]] <= cval_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_s1    <= op;
			emit_s1  <= emit;
			cidx_s1  <= coef_index;
			cval_s1  <= coef_value;
			pix_s1   <= wr_word;
			slot_s1  <= m;
			pos_s1.x <= x - POS_W'(hp);
			pos_s1.y <= y - POS_W'(vp);
		end
		if (en2 && valid_s1) begin
			pos_s2 <= pos_s1;
		end
		// window column age 0 is the newest column, row age 0 the current line
		if (en2 && valid_s1 && op_s1 == c2d_pkg::OP_PIXEL) begin
			for (int a = 0; a < ROWS; a++) begin
				for (int b = COLS - 1; b > 0; b--) begin
					win_q[a][b] <= win_q[a][b-1];
				end
				win_q[a][0] <= (a == 0) ? pix_s1 : rd_word[row_bank(slot_s1, a)];
			end
		end
	end

	c2d_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s2),
		.in_ready (mac_ready),
		.win      (win_q),
		.coefs    (coef_q),
		.mode     (mode),
		.pos      (pos_s2),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_x    (out_x),
		.out_y    (out_y),
		.out_ch0  (out_ch0),
		.out_ch1  (out_ch1),
		.out_ch2  (out_ch2)
	);

`ifndef NO_ASSERTIONS
	a_rmod_range: assert property (@(posedge clk) disable iff (!arst_n)
		rmod_q <= AGE_W'(ROWS - 1))
		else $error("line buffer bank index out of range");

	a_s2_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(valid_s1 && op_s1 == c2d_pkg::OP_PIXEL && emit_s1))
		else $error("window stage filled without an interior pixel word");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		acc_pix && frame_start |=> rmod_q <= AGE_W'(1))
		else $error("frame start did not restart the line bank rotation");
`endif

endmodule

`default_nettype wire

// File: dv/testbench.sv
// testbench for fixed_point_2d_convolution: directed words, then random frame setups
// self-checking against an in-bench q13 convolution predictor; depends on c2d_pkg and the rtl
`timescale 1ns / 100ps

module testbench;

	localparam int POS_W           = c2d_pkg::POS_W;
	localparam int PIX_W           = c2d_pkg::PIX_W;
	localparam int CIDX_W          = c2d_pkg::CIDX_W;
	localparam int COEF_W          = c2d_pkg::COEF_W;
	localparam int DIM_W           = c2d_pkg::DIM_W;
	localparam int WSIZE_W         = c2d_pkg::WSIZE_W;
	localparam int WORD_W          = c2d_pkg::WORD_W;
	localparam int CFG_IDX_W       = c2d_pkg::CFG_IDX_W;
	localparam int ACC_W           = c2d_pkg::ACC_W;
	localparam int NUM_CH          = c2d_pkg::NUM_CH;
	localparam int NUM_COEFS       = c2d_pkg::NUM_COEFS;
	localparam int MAX_WINDOW_ROWS = c2d_pkg::MAX_WINDOW_ROWS;
	localparam int MAX_WINDOW_COLS = c2d_pkg::MAX_WINDOW_COLS;
	localparam int MAX_LINE_PIXELS = c2d_pkg::MAX_LINE_PIXELS;
	localparam int MAX_LINES       = c2d_pkg::MAX_LINES;
	localparam int FRACTION_SCALE  = c2d_pkg::FRACTION_SCALE;

	localparam int unsigned CYCLE_LIMIT    = 600000;
	localparam int unsigned ITEM_TARGET    = 650;
	localparam int unsigned SHOWN_FAILURES = 10;

	typedef struct packed {
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic [PIX_W-1:0] ch0;
		logic [PIX_W-1:0] ch1;
		logic [PIX_W-1:0] ch2;
	} pixel_result_t;

	typedef struct packed {
		logic              op;
		logic              fs;
		logic [PIX_W-1:0]  p0;
		logic [PIX_W-1:0]  p1;
		logic [PIX_W-1:0]  p2;
		logic [CIDX_W-1:0] cidx;
		logic [COEF_W-1:0] cval;
		logic              typed;
		pixel_result_t     want;
	} directed_row_t;

	localparam pixel_result_t NO_PIXEL = '0;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic                     op;
	logic                     frame_start;
	logic [PIX_W-1:0]         pixel_ch0;
	logic [PIX_W-1:0]         pixel_ch1;
	logic [PIX_W-1:0]         pixel_ch2;
	logic [CIDX_W-1:0]        coef_index;
	logic signed [COEF_W-1:0] coef_value;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [DIM_W-1:0]         cfg_data;
	logic                     out_valid;
	logic                     out_ready;
	logic [POS_W-1:0]         out_x;
	logic [POS_W-1:0]         out_y;
	logic [PIX_W-1:0]         out_ch0;
	logic [PIX_W-1:0]         out_ch1;
	logic [PIX_W-1:0]         out_ch2;

	fixed_point_2d_convolution dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.frame_start(frame_start),
		.pixel_ch0  (pixel_ch0),
		.pixel_ch1  (pixel_ch1),
		.pixel_ch2  (pixel_ch2),
		.coef_index (coef_index),
		.coef_value (coef_value),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_x      (out_x),
		.out_y      (out_y),
		.out_ch0    (out_ch0),
		.out_ch1    (out_ch1),
		.out_ch2    (out_ch2)
	);

	// predictor state
	logic [DIM_W-1:0]   reg_width  = 11'd1024;
	logic [DIM_W-1:0]   reg_height = 11'd1024;
	logic               reg_color  = 1'b0;
	logic [WSIZE_W-1:0] reg_cols   = 3'd3;
	logic [WSIZE_W-1:0] reg_rows   = 3'd3;
	bit [WORD_W-1:0]    line_mem [MAX_WINDOW_ROWS][MAX_LINE_PIXELS];
	logic [COEF_W-1:0]  coef_mem [NUM_COEFS];
	int unsigned        col_pos = 0;
	int unsigned        row_pos = 0;

	pixel_result_t expected_pixels [$];
	int unsigned   fail_count   = 0;
	int unsigned   results_seen = 0;
	int unsigned   items_sent   = 0;
	int unsigned   cycle_count  = 0;
	bit            sender_steady = 1'b0;

	directed_row_t directed_rows [20] = '{
		'{c2d_pkg::OP_COEF, 1'b1, 8'd0, 8'd0, 8'd0, 5'd0, 32'd8192, 1'b0, NO_PIXEL},
		'{c2d_pkg::OP_COEF, 1'b0, 8'hFF, 8'hFF, 8'hFF, 5'd31, 32'h12345678, 1'b0, NO_PIXEL},
		'{c2d_pkg::OP_COEF, 1'b0, 8'd0, 8'd0, 8'd0, 5'd25, 32'hFFFFFFFF, 1'b0, NO_PIXEL},
		'{c2d_pkg::OP_PIXEL, 1'b1, 8'd255, 8'd0, 8'd255, 5'd0, 32'd0, 1'b1,
			'{10'd0, 10'd0, 8'd255, 8'd0, 8'd255}},
		'{c2d_pkg::OP_PIXEL, 1'b0, 8'd0, 8'd255, 8'd0, 5'd31, 32'hFFFFFFFF, 1'b1,
			'{10'd1, 10'd0, 8'd0, 8'd255, 8'd0}},
		'{c2d_pkg::OP_PIXEL, 1'b0, 8'd1, 8'd2, 8'd3, 5'd0, 32'd0, 1'b1,
			'{10'd2, 10'd0, 8'd1, 8'd2, 8'd3}},
		'{c2d_pkg::OP_PIXEL, 1'b0, 8'd128, 8'd64, 8'd32, 5'd0, 32'd0, 1'b1,
			'{10'd3, 10'd0, 8'd128, 8'd64, 8'd32}},
		'{c2d_pkg::OP_PIXEL, 1'b0, 8'd7, 8'd8, 8'd9, 5'd0, 32'd0, 1'b1,
			'{10'd0, 10'd1, 8'd7, 8'd8, 8'd9}},
		'{c2d_pkg::OP_COEF, 1'b0, 8'd0, 8'd0, 8'd0, 5'd0, 32'hFFFFE000, 1'b0, NO_PIXEL},
		'{c2d_pkg::OP_PIXEL, 1'b0, 8'd255, 8'd1, 8'd0, 5'd0, 32'd0, 1'b1,
			'{10'd1, 10'd1, 8'h01, 8'hFF, 8'h00}},
		'{c2d_pkg::OP_COEF, 1'b0, 8'd0, 8'd0, 8'd0, 5'd0, 32'h7FFFFFFF, 1'b0, NO_PIXEL},
		'{c2d_pkg::OP_PIXEL, 1'b0, 8'd1, 8'd255, 8'd2, 5'd0, 32'd0, 1'b0, NO_PIXEL},
		'{c2d_pkg::OP_COEF, 1'b0, 8'd0, 8'd0, 8'd0, 5'd0, 32'h80000000, 1'b0, NO_PIXEL},
		'{c2d_pkg::OP_PIXEL, 1'b0, 8'd1, 8'd0, 8'd255, 5'd0, 32'd0, 1'b0, NO_PIXEL},
		'{c2d_pkg::OP_COEF, 1'b0, 8'd0, 8'd0, 8'd0, 5'd0, 32'd16384, 1'b0, NO_PIXEL},
		'{c2d_pkg::OP_PIXEL, 1'b0, 8'd200, 8'd127, 8'd128, 5'd0, 32'd0, 1'b0, NO_PIXEL},
		'{c2d_pkg::OP_COEF, 1'b0, 8'd0, 8'd0, 8'd0, 5'd0, 32'd4096, 1'b0, NO_PIXEL},
		'{c2d_pkg::OP_PIXEL, 1'b1, 8'd3, 8'd255, 8'd254, 5'd0, 32'd0, 1'b0, NO_PIXEL},
		'{c2d_pkg::OP_COEF, 1'b0, 8'd0, 8'd0, 8'd0, 5'd24, 32'h55555555, 1'b0, NO_PIXEL},
		'{c2d_pkg::OP_PIXEL, 1'b0, 8'd0, 8'd0, 8'd0, 5'd0, 32'd0, 1'b0, NO_PIXEL}
	};

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_count,
				expected_pixels.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic int unsigned clamp_span(int unsigned n, int unsigned top);
		if (n == 0) return 1;
		return (n > top) ? top : n;
	endfunction

	function automatic int unsigned half_span(int unsigned n, int unsigned top);
		return (clamp_span(n, top) - 1) / 2;
	endfunction

	// divide by the q13 scale toward zero, keep the low byte
	function automatic logic [PIX_W-1:0] scale_down(logic [ACC_W-1:0] acc);
		int q;
		q = $signed(acc) / FRACTION_SCALE;
		return q[PIX_W-1:0];
	endfunction

	task automatic filter_pixel(input logic fs, input logic [PIX_W-1:0] s0, s1, s2,
		output bit produced, output pixel_result_t res);
		int unsigned w, h, hp, vp, taps, x, y, top, left;
		logic [ACC_W-1:0] acc [NUM_CH];
		bit [WORD_W-1:0] pix;
		logic [COEF_W-1:0] k;
		w = clamp_span(reg_width, MAX_LINE_PIXELS);
		h = clamp_span(reg_height, MAX_LINES);
		hp = half_span(reg_cols, MAX_WINDOW_COLS);
		vp = half_span(reg_rows, MAX_WINDOW_ROWS);
		taps = 2 * hp + 1;
		produced = 1'b0;
		res = NO_PIXEL;
		if (fs) begin
			col_pos = 0;
			row_pos = 0;
		end
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
		end
		if (row_pos >= h) row_pos = 0;
		x = col_pos;
		y = row_pos;
		line_mem[y % MAX_WINDOW_ROWS][x] = {s2, s1, s0};
		if (x >= 2 * hp && y >= 2 * vp) begin
			top = y - 2 * vp;
			left = x - 2 * hp;
			for (int ch = 0; ch < NUM_CH; ch++) acc[ch] = '0;
			for (int r = 0; r < 2 * vp + 1; r++) begin
				for (int c = 0; c < taps; c++) begin
					pix = line_mem[(top + r) % MAX_WINDOW_ROWS][left + c];
					k = coef_mem[r * taps + c];
					for (int ch = 0; ch < NUM_CH; ch++)
						acc[ch] = acc[ch] + 32'(pix[PIX_W*ch +: PIX_W]) * k;
				end
			end
			res.x = POS_W'(x - hp);
			res.y = POS_W'(y - vp);
			res.ch0 = scale_down(acc[0]);
			res.ch1 = reg_color ? scale_down(acc[1]) : '0;
			res.ch2 = reg_color ? scale_down(acc[2]) : '0;
			produced = 1'b1;
		end
		col_pos = x + 1;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos = y + 1;
			if (row_pos >= h) row_pos = 0;
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			c2d_pkg::CFG_IMAGE_WIDTH: reg_width = data;
			c2d_pkg::CFG_IMAGE_HEIGHT: reg_height = data;
			c2d_pkg::CFG_COLOR_MODE: reg_color = data[0];
			c2d_pkg::CFG_WINDOW_COLS: reg_cols = data[WSIZE_W-1:0];
			c2d_pkg::CFG_WINDOW_ROWS: reg_rows = data[WSIZE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic send_word(input logic w_op, w_fs, input logic [PIX_W-1:0] s0, s1, s2,
		input logic [CIDX_W-1:0] ci, input logic [COEF_W-1:0] cv,
		input bit typed, input pixel_result_t want);
		bit produced;
		pixel_result_t got;
		in_valid <= 1'b1;
		op <= w_op;
		frame_start <= w_fs;
		pixel_ch0 <= s0;
		pixel_ch1 <= s1;
		pixel_ch2 <= s2;
		coef_index <= ci;
		coef_value <= cv;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		if (w_op == c2d_pkg::OP_COEF) begin
			if (ci < NUM_COEFS) coef_mem[ci] = cv;
		end else begin
			filter_pixel(w_fs, s0, s1, s2, produced, got);
			if (typed) expected_pixels.push_back(want);
			else if (produced) expected_pixels.push_back(got);
		end
	endtask

	task automatic pause_sender();
		int unsigned r, gap;
		r = $urandom_range(0, 99);
		if (sender_steady || r < 55) gap = 0;
		else if (r < 88) gap = $urandom_range(1, 3);
		else if (r < 98) gap = $urandom_range(4, 12);
		else gap = $urandom_range(20, 60);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [PIX_W-1:0] rand_sample();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0) return '0;
		if (r == 1) return '1;
		return PIX_W'($urandom_range(0, 255));
	endfunction

	function automatic logic [COEF_W-1:0] rand_coef();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0) return $urandom;
		if (r == 1) return $urandom_range(0, 1) ? 32'd8192 : 32'hFFFFE000;
		return 32'($urandom_range(0, 6000)) - 32'd2000;
	endfunction

	task automatic offer_pixel(input logic fs);
		pause_sender();
		send_word(c2d_pkg::OP_PIXEL, fs, rand_sample(), rand_sample(), rand_sample(),
			CIDX_W'($urandom), $urandom, 1'b0, NO_PIXEL);
	endtask

	task automatic offer_coef(input logic [CIDX_W-1:0] idx);
		pause_sender();
		send_word(c2d_pkg::OP_COEF, 1'($urandom), rand_sample(), rand_sample(), rand_sample(),
			idx, rand_coef(), 1'b0, NO_PIXEL);
	endtask

	task automatic wait_drained();
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// output side: random stalls, ready stretches, and long hold-offs
	initial begin
		int unsigned mode_left, stall_left, hold_mark;
		bit steady;
		mode_left = 0;
		stall_left = 0;
		hold_mark = 60;
		steady = 1'b0;
		out_ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (results_seen >= hold_mark) begin
				hold_mark = hold_mark + 250;
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
			end else begin
				if (mode_left == 0) begin
					steady = ($urandom_range(0, 2) == 0);
					mode_left = $urandom_range(30, 200);
				end
				mode_left--;
				if (stall_left > 0) begin
					stall_left--;
					out_ready <= 1'b0;
				end else if (steady) begin
					out_ready <= 1'b1;
				end else if ($urandom_range(0, 99) < 3) begin
					stall_left = $urandom_range(15, 50);
					out_ready <= 1'b0;
				end else begin
					out_ready <= ($urandom_range(0, 99) < 65);
				end
				@(posedge clk);
			end
		end
	end

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= SHOWN_FAILURES) $display("%s", msg);
	endtask

	always @(posedge clk) begin
		pixel_result_t e;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_pixels.size() == 0) begin
				note_failure($sformatf("unexpected word x=%0d y=%0d ch=%h %h %h",
					out_x, out_y, out_ch0, out_ch1, out_ch2));
			end else begin
				e = expected_pixels.pop_front();
				if (out_x !== e.x || out_y !== e.y || out_ch0 !== e.ch0 ||
					out_ch1 !== e.ch1 || out_ch2 !== e.ch2)
					note_failure($sformatf(
						"mismatch: want x=%0d y=%0d ch=%h %h %h, got x=%0d y=%0d ch=%h %h %h",
						e.x, e.y, e.ch0, e.ch1, e.ch2,
						out_x, out_y, out_ch0, out_ch1, out_ch2));
			end
		end
	end

	initial begin
		int unsigned old_w, new_w, npix, ntaps, phase;
		bit force_start, big;
		logic fs;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		op <= c2d_pkg::OP_PIXEL;
		frame_start <= 1'b0;
		pixel_ch0 <= '0;
		pixel_ch1 <= '0;
		pixel_ch2 <= '0;
		coef_index <= '0;
		coef_value <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= c2d_pkg::CFG_IMAGE_WIDTH;
		cfg_data <= '0;
		foreach (coef_mem[i]) coef_mem[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// small color frame with a 1x1 kernel
		write_reg(c2d_pkg::CFG_IMAGE_WIDTH, 11'd4);
		write_reg(c2d_pkg::CFG_IMAGE_HEIGHT, 11'd2);
		write_reg(c2d_pkg::CFG_COLOR_MODE, 11'd1);
		write_reg(c2d_pkg::CFG_WINDOW_COLS, 11'd1);
		write_reg(c2d_pkg::CFG_WINDOW_ROWS, 11'd1);
		write_reg(c2d_pkg::CFG_WINDOW_ROWS + 3'd1, 11'h5A5);
		write_reg(c2d_pkg::CFG_WINDOW_ROWS + 3'd3, 11'h7FF);
		cfg_valid <= 1'b0;
		foreach (directed_rows[i]) begin
			pause_sender();
			send_word(directed_rows[i].op, directed_rows[i].fs, directed_rows[i].p0,
				directed_rows[i].p1, directed_rows[i].p2, directed_rows[i].cidx,
				directed_rows[i].cval, directed_rows[i].typed, directed_rows[i].want);
		end
		in_valid <= 1'b0;
		wait_drained();

		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			old_w = clamp_span(reg_width, MAX_LINE_PIXELS);
			case (phase)
				0: begin
					write_reg(c2d_pkg::CFG_IMAGE_WIDTH, 11'd0);
					write_reg(c2d_pkg::CFG_IMAGE_HEIGHT, 11'd7);
					write_reg(c2d_pkg::CFG_COLOR_MODE, 11'd0);
					write_reg(c2d_pkg::CFG_WINDOW_COLS, 11'd1);
					write_reg(c2d_pkg::CFG_WINDOW_ROWS, 11'd3);
				end
				1: begin
					write_reg(c2d_pkg::CFG_IMAGE_WIDTH, 11'd2047);
					write_reg(c2d_pkg::CFG_IMAGE_HEIGHT, 11'd2047);
					write_reg(c2d_pkg::CFG_COLOR_MODE, 11'd1);
					write_reg(c2d_pkg::CFG_WINDOW_COLS, 11'd0);
					write_reg(c2d_pkg::CFG_WINDOW_ROWS, 11'd0);
				end
				2: begin
					write_reg(c2d_pkg::CFG_IMAGE_WIDTH, 11'd8);
					write_reg(c2d_pkg::CFG_IMAGE_HEIGHT, 11'd6);
					write_reg(c2d_pkg::CFG_COLOR_MODE, 11'h7FE);
					write_reg(c2d_pkg::CFG_WINDOW_COLS, 11'd7);
					write_reg(c2d_pkg::CFG_WINDOW_ROWS, 11'd7);
				end
				3: begin
					write_reg(c2d_pkg::CFG_IMAGE_WIDTH, 11'd6);
					write_reg(c2d_pkg::CFG_IMAGE_HEIGHT, 11'd5);
					write_reg(c2d_pkg::CFG_COLOR_MODE, 11'd1);
					write_reg(c2d_pkg::CFG_WINDOW_COLS, 11'd2);
					write_reg(c2d_pkg::CFG_WINDOW_ROWS, 11'h7FC);
				end
				4: begin
					write_reg(c2d_pkg::CFG_IMAGE_WIDTH, 11'd1024);
					write_reg(c2d_pkg::CFG_IMAGE_HEIGHT, 11'd0);
					write_reg(c2d_pkg::CFG_WINDOW_COLS, 11'd1);
					write_reg(c2d_pkg::CFG_WINDOW_ROWS, 11'd1);
				end
				default: begin
					big = ($urandom_range(0, 6) == 0);
					if (big || $urandom_range(0, 3) != 0)
						write_reg(c2d_pkg::CFG_IMAGE_WIDTH,
							big ? DIM_W'($urandom_range(1000, 2047)) :
							DIM_W'($urandom_range(0, 12)));
					if ($urandom_range(0, 3) != 0)
						write_reg(c2d_pkg::CFG_IMAGE_HEIGHT, ($urandom_range(0, 9) == 0) ?
							DIM_W'($urandom_range(1000, 2047)) : DIM_W'($urandom_range(0, 9)));
					if ($urandom_range(0, 2) != 0)
						write_reg(c2d_pkg::CFG_COLOR_MODE, DIM_W'($urandom));
					if (big || $urandom_range(0, 3) != 0)
						write_reg(c2d_pkg::CFG_WINDOW_COLS, big ? DIM_W'($urandom_range(0, 2)) :
							DIM_W'($urandom));
					if (big || $urandom_range(0, 3) != 0)
						write_reg(c2d_pkg::CFG_WINDOW_ROWS, big ? DIM_W'($urandom_range(0, 2)) :
							DIM_W'($urandom));
					if ($urandom_range(0, 3) == 0)
						write_reg(c2d_pkg::CFG_WINDOW_ROWS + CFG_IDX_W'($urandom_range(1, 3)),
							DIM_W'($urandom));
				end
			endcase
			cfg_valid <= 1'b0;

			// a wider line than before would read store entries never written this frame
			new_w = clamp_span(reg_width, MAX_LINE_PIXELS);
			force_start = (new_w > old_w);
			npix = (new_w > 64) ? 20 : $urandom_range(35, 75);
			ntaps = (2 * half_span(reg_cols, MAX_WINDOW_COLS) + 1) *
				(2 * half_span(reg_rows, MAX_WINDOW_ROWS) + 1);
			sender_steady = ($urandom_range(0, 3) == 0);

			if (phase < 5 || $urandom_range(0, 4) != 0)
				for (int j = 0; j < ntaps; j++) offer_coef(CIDX_W'(j));
			repeat ($urandom_range(0, 2)) offer_coef(CIDX_W'($urandom_range(0, 31)));

			for (int i = 0; i < npix; i++) begin
				if ($urandom_range(0, 29) == 0) offer_coef(CIDX_W'($urandom_range(0, 31)));
				if (i == 0) fs = force_start || ($urandom_range(0, 3) != 0);
				else fs = ($urandom_range(0, 39) == 0);
				offer_pixel(fs);
			end
			in_valid <= 1'b0;
			wait_drained();
			phase++;
		end

		repeat (20) @(posedge clk);
		if (expected_pixels.size() != 0)
			note_failure($sformatf("%0d results never arrived", expected_pixels.size()));
		if (fail_count > SHOWN_FAILURES) $display("%0d mismatches in total", fail_count);
		$display("checked %0d filtered pixels from %0d words over %0d frame setups",
			results_seen, items_sent, phase + 1);
		$display("setups spanned zero to full-scale sizes, 1x1 to 5x5 kernels, mono and color");
		if (fail_count == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end

endmodule

// File: files.f
src/c2d_pkg.sv
src/c2d_ram.sv
src/c2d_mac.sv
src/fixed_point_2d_convolution.sv
dv/testbench.sv
